### hw/rtl/camera_look_at_matrix_unit_macros.svh
// Assertion macros shared by the look-at matrix checker.
`ifndef CAMERA_LOOK_AT_MATRIX_UNIT_MACROS_SVH
`define CAMERA_LOOK_AT_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define CLAM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is held.
`define CLAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/clam_pkg.sv
// Shared types, constants and saturation helpers of the look-at matrix unit.
package clam_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned WIDE_W = 68;

    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic        [WORD_W-1:0]   t_mag;
    typedef logic signed [2*WORD_W-1:0] t_prod;
    typedef logic signed [WIDE_W-1:0]   t_wide;
    typedef t_word [2:0]                t_vec3;
    typedef logic [1:0]                 t_row;

    localparam t_row ROW_X = 2'd0;
    localparam t_row ROW_Y = 2'd1;
    localparam t_row ROW_Z = 2'd2;
    localparam t_row ROW_T = 2'd3;

    localparam t_word WORD_MAX = 32'sh7fff_ffff;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    // Finished matrix: s, u and -f columns, plus the translation row.
    typedef struct packed {
        t_vec3 s;
        t_vec3 u;
        t_vec3 nf;
        t_vec3 tr;
    } t_view;

    function automatic t_word sat_word(input t_wide x);
        t_word y;
        if (x > t_wide'(WORD_MAX)) begin
            y = WORD_MAX;
        end else if (x < t_wide'(WORD_MIN)) begin
            y = WORD_MIN;
        end else begin
            y = t_word'(x);
        end
        return y;
    endfunction

    function automatic t_word neg_sat(input t_word x);
        t_word y;
        if (x == WORD_MIN) begin
            y = WORD_MAX;
        end else begin
            y = -x;
        end
        return y;
    endfunction

endpackage

### hw/rtl/clam_norm.sv
// Pipelined 3-vector normaliser: pre-shift, sum of squares, root and divide.
module clam_norm #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  clam_pkg::t_vec3    i_vec,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output clam_pkg::t_vec3    o_vec,
    output logic [SIDE_W-1:0]  o_side
);
    import clam_pkg::*;

    localparam int SH_N  = 5;
    localparam int SQ_N  = WORD_W;
    localparam int SQ_W  = 2 * WORD_W;
    localparam int DIV_N = FRAC_BITS + 1;
    localparam int NUM_W = WORD_W + 1 + FRAC_BITS;

    typedef struct packed {
        logic [2:0]        neg;
        t_mag [2:0]        mag;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } t_nc;

    typedef struct packed {
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } t_nd;

    // ---- magnitude and pre-shift stages
    logic r_sh_v [0:SH_N];
    t_nc  r_sh   [0:SH_N];
    t_nc  n_ab;

    always_comb begin
        n_ab.side = i_side;
        for (int i = 0; i < 3; i++) begin
            n_ab.neg[i] = i_vec[i][WORD_W-1];
            n_ab.mag[i] = n_ab.neg[i] ? t_mag'(-i_vec[i]) : t_mag'(i_vec[i]);
        end
        n_ab.zero = ((n_ab.mag[0] | n_ab.mag[1] | n_ab.mag[2]) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_v[0] <= 1'b0;
        end else if (i_en) begin
            r_sh_v[0] <= i_valid;
        end
        if (i_en) begin
            r_sh[0] <= n_ab;
        end
    end

    for (genvar k = 1; k <= SH_N; k++) begin : g_sh
        localparam int SA = 1 << (SH_N - k);
        t_mag m_or;
        t_nc  nx;
        always_comb begin
            m_or = r_sh[k-1].mag[0] | r_sh[k-1].mag[1] | r_sh[k-1].mag[2];
            nx   = r_sh[k-1];
            // shift only while the largest magnitude stays below 2^31
            if ((m_or >> (WORD_W - 1 - SA)) == '0) begin
                for (int i = 0; i < 3; i++) begin
                    nx.mag[i] = r_sh[k-1].mag[i] << SA;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sh_v[k] <= 1'b0;
            end else if (i_en) begin
                r_sh_v[k] <= r_sh_v[k-1];
            end
            if (i_en) begin
                r_sh[k] <= nx;
            end
        end
    end

    // ---- squares
    logic                 r_sq_v;
    logic [2:0][SQ_W-1:0] r_sq;
    t_nc                  r_sq_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (i_en) begin
            r_sq_v <= r_sh_v[SH_N];
        end
        if (i_en) begin
            r_sq_c <= r_sh[SH_N];
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SQ_W'(r_sh[SH_N].mag[i]) * SQ_W'(r_sh[SH_N].mag[i]);
            end
        end
    end

    // ---- integer square root, one result bit per stage
    logic            r_rt_v   [0:SQ_N];
    t_nc             r_rt_c   [0:SQ_N];
    logic [SQ_W-1:0] r_rt_n   [0:SQ_N-1];
    logic [SQ_W-1:0] r_rt_res [1:SQ_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_v[0] <= 1'b0;
        end else if (i_en) begin
            r_rt_v[0] <= r_sq_v;
        end
        if (i_en) begin
            r_rt_c[0] <= r_sq_c;
            r_rt_n[0] <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    for (genvar i = 1; i <= SQ_N; i++) begin : g_rt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 * i);
        logic [SQ_W-1:0] res_p;
        logic [SQ_W-1:0] trial;
        logic            take;
        if (i == 1) begin : g_first
            assign res_p = '0;
        end else begin : g_rest
            assign res_p = r_rt_res[i-1];
        end
        assign trial = res_p + BIT;
        assign take  = (r_rt_n[i-1] >= trial);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_v[i] <= 1'b0;
            end else if (i_en) begin
                r_rt_v[i] <= r_rt_v[i-1];
            end
            if (i_en) begin
                r_rt_c[i]   <= r_rt_c[i-1];
                r_rt_res[i] <= take ? (res_p >> 1) + BIT : (res_p >> 1);
            end
        end
        if (i < SQ_N) begin : g_n
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rt_n[i] <= take ? r_rt_n[i-1] - trial : r_rt_n[i-1];
                end
            end
        end
    end

    // ---- rounded division by the length, one quotient bit per stage
    logic                  r_dv_v   [0:DIV_N];
    t_nd                   r_dv_c   [0:DIV_N];
    t_mag                  r_dv_len [0:DIV_N-1];
    logic [2:0][WORD_W-1:0] r_dv_rem [0:DIV_N-1];
    logic [2:0][DIV_N-1:0] r_dv_low [0:DIV_N-1];
    logic [2:0][DIV_N-1:0] r_dv_q   [1:DIV_N];

    t_mag             len;
    logic [NUM_W-1:0] num [3];

    assign len = r_rt_res[SQ_N][WORD_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num[i] = (NUM_W'(r_rt_c[SQ_N].mag[i]) << FRAC_BITS) + NUM_W'(len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_rt_v[SQ_N];
        end
        if (i_en) begin
            r_dv_c[0].neg  <= r_rt_c[SQ_N].neg;
            r_dv_c[0].zero <= r_rt_c[SQ_N].zero;
            r_dv_c[0].side <= r_rt_c[SQ_N].side;
            r_dv_len[0]    <= len;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= num[i][NUM_W-1:DIV_N];
                r_dv_low[0][i] <= num[i][DIV_N-1:0];
            end
        end
    end

    for (genvar j = 1; j <= DIV_N; j++) begin : g_dv
        logic [2:0][DIV_N-1:0] q_p;
        logic [2:0][WORD_W:0]  tr;
        logic [2:0][WORD_W:0]  df;
        logic [2:0]            qb;
        if (j == 1) begin : g_first
            assign q_p = '0;
        end else begin : g_rest
            assign q_p = r_dv_q[j-1];
        end
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                tr[i] = {r_dv_rem[j-1][i], r_dv_low[j-1][i][DIV_N-1]};
                df[i] = tr[i] - {1'b0, r_dv_len[j-1]};
                qb[i] = !df[i][WORD_W];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
            if (i_en) begin
                r_dv_c[j] <= r_dv_c[j-1];
                for (int i = 0; i < 3; i++) begin
                    r_dv_q[j][i] <= {q_p[i][DIV_N-2:0], qb[i]};
                end
            end
        end
        if (j < DIV_N) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv_len[j] <= r_dv_len[j-1];
                    for (int i = 0; i < 3; i++) begin
                        r_dv_rem[j][i] <= qb[i] ? df[i][WORD_W-1:0] : tr[i][WORD_W-1:0];
                        r_dv_low[j][i] <= r_dv_low[j-1][i] << 1;
                    end
                end
            end
        end
    end

    // ---- sign and zero-length fix-up
    logic              r_o_v;
    t_vec3             r_o_vec;
    logic [SIDE_W-1:0] r_o_side;
    t_vec3             n_o_vec;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_c[DIV_N].zero) begin
                n_o_vec[i] = '0;
            end else if (r_dv_c[DIV_N].neg[i]) begin
                n_o_vec[i] = -t_word'(WORD_W'(r_dv_q[DIV_N][i]));
            end else begin
                n_o_vec[i] = t_word'(WORD_W'(r_dv_q[DIV_N][i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_dv_v[DIV_N];
        end
        if (i_en) begin
            r_o_vec  <= n_o_vec;
            r_o_side <= r_dv_c[DIV_N].side;
        end
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o_vec;
    assign o_side  = r_o_side;

endmodule

### hw/rtl/clam_cross.sv
// Three-stage pipelined cross product with rounding and saturation.
module clam_cross #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  clam_pkg::t_vec3    i_a,
    input  clam_pkg::t_vec3    i_b,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output clam_pkg::t_vec3    o_vec,
    output logic [SIDE_W-1:0]  o_side
);
    import clam_pkg::*;

    localparam t_wide RND = t_wide'(1) << (FRAC_BITS - 1);

    logic              r_p_v, r_d_v, r_o_v;
    t_prod             r_p [6];
    t_wide             r_d [3];
    t_vec3             r_o_vec;
    logic [SIDE_W-1:0] r_p_side, r_d_side, r_o_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_d_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
            r_d_v <= r_p_v;
            r_o_v <= r_d_v;
        end
        if (i_en) begin
            r_p[0] <= t_prod'($signed(i_a[1])) * t_prod'($signed(i_b[2]));
            r_p[1] <= t_prod'($signed(i_a[2])) * t_prod'($signed(i_b[1]));
            r_p[2] <= t_prod'($signed(i_a[2])) * t_prod'($signed(i_b[0]));
            r_p[3] <= t_prod'($signed(i_a[0])) * t_prod'($signed(i_b[2]));
            r_p[4] <= t_prod'($signed(i_a[0])) * t_prod'($signed(i_b[1]));
            r_p[5] <= t_prod'($signed(i_a[1])) * t_prod'($signed(i_b[0]));
            for (int i = 0; i < 3; i++) begin
                r_d[i]      <= t_wide'(r_p[2*i]) - t_wide'(r_p[2*i+1]) + RND;
                r_o_vec[i]  <= sat_word(r_d[i] >>> FRAC_BITS);
            end
            r_p_side <= i_side;
            r_d_side <= r_p_side;
            r_o_side <= r_d_side;
        end
    end

    assign o_valid = r_o_v;
    assign o_vec   = r_o_vec;
    assign o_side  = r_o_side;

endmodule

### hw/rtl/clam_dot.sv
// Translation row: three pipelined dot products against the eye position.
module clam_dot #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  clam_pkg::t_vec3 i_s,
    input  clam_pkg::t_vec3 i_u,
    input  clam_pkg::t_vec3 i_f,
    input  clam_pkg::t_vec3 i_eye,
    output logic            o_valid,
    output clam_pkg::t_view o_view
);
    import clam_pkg::*;

    localparam t_wide RND = t_wide'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        t_vec3 s;
        t_vec3 u;
        t_vec3 nf;
    } t_cols;

    logic  r_p_v, r_q_v, r_o_v;
    t_prod r_p [9];
    t_wide r_q [3];
    t_cols r_p_c, r_q_c;
    t_view r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_q_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
            r_q_v <= r_p_v;
            r_o_v <= r_q_v;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i]      <= t_prod'($signed(i_s[i])) * t_prod'($signed(i_eye[i]));
                r_p[3+i]    <= t_prod'($signed(i_u[i])) * t_prod'($signed(i_eye[i]));
                r_p[6+i]    <= t_prod'($signed(i_f[i])) * t_prod'($signed(i_eye[i]));
                r_p_c.nf[i] <= neg_sat(i_f[i]);
            end
            r_p_c.s <= i_s;
            r_p_c.u <= i_u;
            for (int k = 0; k < 3; k++) begin
                r_q[k] <= t_wide'(r_p[3*k]) + t_wide'(r_p[3*k+1]) + t_wide'(r_p[3*k+2]) + RND;
            end
            r_q_c <= r_p_c;
            r_o.s     <= r_q_c.s;
            r_o.u     <= r_q_c.u;
            r_o.nf    <= r_q_c.nf;
            r_o.tr[0] <= neg_sat(sat_word(r_q[0] >>> FRAC_BITS));
            r_o.tr[1] <= neg_sat(sat_word(r_q[1] >>> FRAC_BITS));
            r_o.tr[2] <= sat_word(r_q[2] >>> FRAC_BITS);
        end
    end

    assign o_valid = r_o_v;
    assign o_view  = r_o;

endmodule

### hw/rtl/camera_look_at_matrix_unit.sv
// Look-at view matrix unit: top level with input stage, datapath chain and row output.
//
// Takes one request (eye, target, up; signed fixed point with FRAC_BITS fraction
// bits) and returns the 4x4 view matrix as four row results, rows 0 to 3, the last
// flagged by o_last_row. Rows 0..2 are (s, u, -f, 0), row 3 is
// (-s.eye, -u.eye, f.eye, 1.0), with f = normalise(target - eye),
// s = normalise(f x up), u = s x f; a zero-length vector normalises to zero and
// every intermediate result saturates. The datapath is one stall-held pipeline:
// difference stage, normaliser (bit-serial square root over 32 stages, one quotient
// bit per stage for the division), cross product, second normaliser, cross product
// and dot-product stage. The single result channel moves one row per cycle while
// i_stall is low; a new request is taken while earlier ones are still in flight,
// and the row register reloads in the same cycle as the last row of the previous
// matrix leaves. o_stall rises only when a finished matrix is waiting at the end
// of the pipeline behind the row register.
module camera_look_at_matrix_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  clam_pkg::t_word   i_eye_x,
    input  clam_pkg::t_word   i_eye_y,
    input  clam_pkg::t_word   i_eye_z,
    input  clam_pkg::t_word   i_target_x,
    input  clam_pkg::t_word   i_target_y,
    input  clam_pkg::t_word   i_target_z,
    input  clam_pkg::t_word   i_up_x,
    input  clam_pkg::t_word   i_up_y,
    input  clam_pkg::t_word   i_up_z,
    output logic              o_valid,
    input  logic              i_stall,
    output clam_pkg::t_row    o_row_index,
    output clam_pkg::t_word   o_elem_0,
    output clam_pkg::t_word   o_elem_1,
    output clam_pkg::t_word   o_elem_2,
    output clam_pkg::t_word   o_elem_3,
    output logic              o_last_row
);
    import clam_pkg::*;

    localparam t_word ONE = t_word'(1) <<< FRAC_BITS;

    typedef struct packed {
        t_vec3 eye;
        t_vec3 up;
    } t_side_f;

    typedef struct packed {
        t_vec3 eye;
        t_vec3 f;
    } t_side_c;

    typedef struct packed {
        t_vec3 eye;
        t_vec3 s;
        t_vec3 f;
    } t_side_u;

    // One enable for the whole pipeline: hold everything while the row
    // register cannot take the matrix sitting at the end.
    logic pipe_en;

    // ---- difference stage
    t_vec3   eye_in, tgt_in, up_in, n_d;
    logic    r_d_v;
    t_vec3   r_d;
    t_side_f r_d_side;

    assign eye_in = {i_eye_z, i_eye_y, i_eye_x};
    assign tgt_in = {i_target_z, i_target_y, i_target_x};
    assign up_in  = {i_up_z, i_up_y, i_up_x};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = sat_word(t_wide'(tgt_in[i]) - t_wide'(eye_in[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (pipe_en) begin
            r_d_v <= i_valid;
        end
        if (pipe_en) begin
            r_d          <= n_d;
            r_d_side.eye <= eye_in;
            r_d_side.up  <= up_in;
        end
    end

    // ---- f = normalise(target - eye)
    logic    f_v;
    t_vec3   f_vec;
    t_side_f f_sd;

    clam_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_f))) u_norm_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (r_d_v),
        .i_vec   (r_d),
        .i_side  (r_d_side),
        .o_valid (f_v),
        .o_vec   (f_vec),
        .o_side  (f_sd)
    );

    // ---- f x up
    logic    c_v;
    t_vec3   c_vec;
    t_side_c c_sd;

    clam_cross #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_c))) u_cross_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (f_v),
        .i_a     (f_vec),
        .i_b     (f_sd.up),
        .i_side  ({f_sd.eye, f_vec}),
        .o_valid (c_v),
        .o_vec   (c_vec),
        .o_side  (c_sd)
    );

    // ---- s = normalise(f x up)
    logic    s_v;
    t_vec3   s_vec;
    t_side_c s_sd;

    clam_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_c))) u_norm_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (c_v),
        .i_vec   (c_vec),
        .i_side  (c_sd),
        .o_valid (s_v),
        .o_vec   (s_vec),
        .o_side  (s_sd)
    );

    // ---- u = s x f
    logic    u_v;
    t_vec3   u_vec;
    t_side_u u_sd;

    clam_cross #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_side_u))) u_cross_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (s_v),
        .i_a     (s_vec),
        .i_b     (s_sd.f),
        .i_side  ({s_sd.eye, s_vec, s_sd.f}),
        .o_valid (u_v),
        .o_vec   (u_vec),
        .o_side  (u_sd)
    );

    // ---- translation row and -f column
    logic  dot_v;
    t_view dot_view;

    clam_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (u_v),
        .i_s     (u_sd.s),
        .i_u     (u_vec),
        .i_f     (u_sd.f),
        .i_eye   (u_sd.eye),
        .o_valid (dot_v),
        .o_view  (dot_view)
    );

    // ---- row register: hold one matrix, advance one row per accepted result
    logic  r_busy;
    t_row  r_row;
    t_view r_view;
    logic  out_take, row_free, load;

    assign out_take = r_busy && !i_stall;
    assign row_free = !r_busy || (out_take && (r_row == ROW_T));
    assign load     = dot_v && row_free;
    assign pipe_en  = !dot_v || row_free;
    assign o_stall  = !pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= ROW_X;
        end else if (load) begin
            r_busy <= 1'b1;
            r_row  <= ROW_X;
        end else if (out_take) begin
            if (r_row == ROW_T) begin
                r_busy <= 1'b0;
            end else begin
                r_row <= t_row'(r_row + 2'd1);
            end
        end
        if (load) begin
            r_view <= dot_view;
        end
    end

    always_comb begin
        case (r_row)
            ROW_X: begin
                o_elem_0 = r_view.s[0];
                o_elem_1 = r_view.u[0];
                o_elem_2 = r_view.nf[0];
                o_elem_3 = '0;
            end
            ROW_Y: begin
                o_elem_0 = r_view.s[1];
                o_elem_1 = r_view.u[1];
                o_elem_2 = r_view.nf[1];
                o_elem_3 = '0;
            end
            ROW_Z: begin
                o_elem_0 = r_view.s[2];
                o_elem_1 = r_view.u[2];
                o_elem_2 = r_view.nf[2];
                o_elem_3 = '0;
            end
            default: begin
                o_elem_0 = r_view.tr[0];
                o_elem_1 = r_view.tr[1];
                o_elem_2 = r_view.tr[2];
                o_elem_3 = ONE;
            end
        endcase
    end

    assign o_valid     = r_busy;
    assign o_row_index = r_row;
    assign o_last_row  = (r_row == ROW_T);

endmodule

### hw/rtl/clam_chk.sv
// Port-level checker for the look-at matrix unit, bound to the top level.
`include "camera_look_at_matrix_unit_macros.svh"

module clam_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input clam_pkg::t_row    o_row_index,
    input clam_pkg::t_word   o_elem_3,
    input logic              o_last_row
);
    import clam_pkg::*;

    `CLAM_ASSERT_NEXT(a_row_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last_row, o_valid && o_row_index == $past(o_row_index) + 2'd1, "row sequence broken")
    `CLAM_ASSERT_NEXT(a_new_matrix, i_clk, i_rst_n, o_valid && !i_stall && o_last_row, !o_valid || o_row_index == ROW_X, "matrix did not restart at row 0")
    `CLAM_ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, o_valid && !o_last_row, o_elem_3 == '0, "rotation row has non-zero last column")
    `CLAM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_row_index), "stalled row moved")

endmodule

bind camera_look_at_matrix_unit clam_chk u_clam_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_row_index (o_row_index),
    .o_elem_3    (o_elem_3),
    .o_last_row  (o_last_row)
);

### tb/tb.sv
// Testbench for the look-at view matrix unit: directed table, random requests, row checking.
module tb;
    import clam_pkg::*;

    localparam int FRAC       = 16;
    localparam int LATENCY    = 97 + 2 * FRAC;
    localparam int CYCLE_CAP  = 400000;
    localparam int N_RANDOM   = 250;
    localparam int N_DIRECTED = 12;

    typedef struct {
        t_row  idx;
        t_word e[4];
        logic  last;
    } t_row_res;

    typedef struct {
        t_word v[9];     // eye xyz, target xyz, up xyz
        bit    typed;    // expected matrix is identity-free camera: all zero, 1.0 in corner
    } t_request;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_word req_in[9];
    logic  o_stall, o_valid, o_last_row;
    t_row  o_row_index;
    t_word o_elem_0, o_elem_1, o_elem_2, o_elem_3;

    t_row_res pending_rows[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       stall_left = 0;
    bit       quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < 9; k++) req_in[k] = '0;
    end

    camera_look_at_matrix_unit #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_eye_x(req_in[0]), .i_eye_y(req_in[1]), .i_eye_z(req_in[2]),
        .i_target_x(req_in[3]), .i_target_y(req_in[4]), .i_target_z(req_in[5]),
        .i_up_x(req_in[6]), .i_up_y(req_in[7]), .i_up_z(req_in[8]),
        .o_valid(o_valid), .i_stall(i_stall), .o_row_index(o_row_index),
        .o_elem_0(o_elem_0), .o_elem_1(o_elem_1), .o_elem_2(o_elem_2),
        .o_elem_3(o_elem_3), .o_last_row(o_last_row)
    );

    // ---------------- predictor ----------------

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Round half upwards to FRAC fraction bits, then clip.
    function automatic longint rescale(longint x);
        return clip32((x + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale to unit length; a zero vector stays zero.
    function automatic void unit_vec(output longint o[3], input longint v[3]);
        logic [63:0] mag[3], top, sum, len, q;
        bit          neg[3];
        top = 0;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = v[k] < 0;
            mag[k] = neg[k] ? -v[k] : v[k];
            if (mag[k] > top) top = mag[k];
        end
        if (top == 0) begin
            for (int k = 0; k < 3; k++) o[k] = 0;
            return;
        end
        while (top < (64'd1 << 30)) begin
            top = top << 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
        len = root_floor(sum);
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << FRAC) + (len >> 1)) / len;
            o[k] = neg[k] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross_vec(output longint o[3], input longint a[3], input longint b[3]);
        o[0] = rescale(a[1] * b[2] - a[2] * b[1]);
        o[1] = rescale(a[2] * b[0] - a[0] * b[2]);
        o[2] = rescale(a[0] * b[1] - a[1] * b[0]);
    endfunction

    function automatic longint dot_vec(longint a[3], longint b[3]);
        return rescale(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    endfunction

    task automatic predict_view_rows(input t_word v[9]);
        longint eye[3], tgt[3], up[3], d[3], f[3], c[3], s[3], u[3];
        longint m[4][4];
        t_row_res r;
        for (int k = 0; k < 3; k++) begin
            eye[k] = longint'(v[k]);
            tgt[k] = longint'(v[3 + k]);
            up[k]  = longint'(v[6 + k]);
            d[k]   = clip32(tgt[k] - eye[k]);
        end
        unit_vec(f, d);
        cross_vec(c, f, up);
        unit_vec(s, c);
        cross_vec(u, s, f);
        for (int k = 0; k < 3; k++) begin
            m[k][0] = s[k];
            m[k][1] = u[k];
            m[k][2] = clip32(-f[k]);
            m[k][3] = 0;
        end
        m[3][0] = clip32(-dot_vec(s, eye));
        m[3][1] = clip32(-dot_vec(u, eye));
        m[3][2] = dot_vec(f, eye);
        m[3][3] = 64'sd1 <<< FRAC;
        for (int k = 0; k < 4; k++) begin
            r.idx  = t_row'(k);
            for (int j = 0; j < 4; j++) r.e[j] = t_word'(m[k][j]);
            r.last = (k == 3);
            pending_rows.push_back(r);
        end
    endtask

    // Degenerate camera: eye on target gives a zero basis and a bare 1.0 corner.
    task automatic push_degenerate_rows();
        t_row_res r;
        for (int k = 0; k < 4; k++) begin
            r.idx  = t_row'(k);
            for (int j = 0; j < 4; j++) r.e[j] = '0;
            if (k == ROW_T) r.e[3] = t_word'(1 << FRAC);
            r.last = (k == ROW_T);
            pending_rows.push_back(r);
        end
    endtask

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        t_row_res want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected row %0d", o_row_index);
            end else begin
                want = pending_rows.pop_front();
                if (o_row_index !== want.idx || o_elem_0 !== want.e[0]
                    || o_elem_1 !== want.e[1] || o_elem_2 !== want.e[2]
                    || o_elem_3 !== want.e[3] || o_last_row !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row mismatch: exp %0d %h %h %h %h %b got %0d %h %h %h %h %b",
                                 want.idx, want.e[0], want.e[1], want.e[2], want.e[3],
                                 want.last, o_row_index, o_elem_0, o_elem_1, o_elem_2,
                                 o_elem_3, o_last_row);
                end
            end
            // Draw the hold-off before the next row.
            stall_left = quiet ? 0 : $urandom_range(0, 13);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_stall <= i_rst_n && (stall_left > 0);
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    // Draw a field: full 32-bit noise, a modest range, or an extreme.
    function automatic t_word rand_field();
        case ($urandom_range(0, 9))
            0, 1, 2: return t_word'($urandom());
            3:       return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            default: return t_word'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    // Hold the request until accepted; a zero gap keeps valid high.
    task automatic send_request(input t_word v[9]);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < 9; k++) req_in[k] <= v[k];
        do @(posedge i_clk); while (o_stall);
    endtask

    t_request directed[N_DIRECTED];
    localparam t_word ONE = t_word'(1 << FRAC);

    initial begin
        t_word v[9];
        // eye, target, up
        directed[0]  = '{'{0, 0, 0, 0, 0, 0, 0, ONE, 0}, 1};          // eye on target
        directed[1]  = '{'{ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0}, 1};
        directed[2]  = '{'{0, 0, ONE, 0, 0, 0, 0, ONE, 0}, 0};        // ordinary camera
        directed[3]  = '{'{0, 0, 0, 0, 0, ONE, 0, 0, ONE}, 0};        // up along view
        directed[4]  = '{'{0, 0, 0, 0, 0, ONE, 0, 0, 0}, 0};          // zero up
        directed[5]  = '{'{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN,
                           0, ONE, 0}, 0};                            // saturating difference
        directed[6]  = '{'{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX,
                           WORD_MAX, WORD_MIN, WORD_MAX}, 0};
        directed[7]  = '{'{WORD_MAX, WORD_MIN, WORD_MAX, 0, 0, 0, ONE, 0, 0}, 0};
        directed[8]  = '{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0};            // tiny vectors
        directed[9]  = '{'{-1, -1, -1, 1, 1, 1, -1, 1, -1}, 0};
        directed[10] = '{'{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                           WORD_MIN, WORD_MIN, WORD_MIN}, 1};
        directed[11] = '{'{32'h1234_5678, -32'sh0ABC_DEF0, 32'h7000_0000, 0, 0, 0,
                           WORD_MIN, WORD_MAX, WORD_MIN}, 0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) begin
            if (directed[n].typed) push_degenerate_rows();
            else predict_view_rows(directed[n].v);
            send_request(directed[n].v);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Run a stretch with no idling on either side.
            quiet = (n >= 100 && n < 140);
            for (int k = 0; k < 9; k++) v[k] = rand_field();
            if ($urandom_range(0, 19) == 0)
                for (int k = 0; k < 3; k++) v[3 + k] = v[k];
            predict_view_rows(v);
            send_request(v);
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && pending_rows.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
